FILE: sv/sks_pkg.sv
// Shared types, codes and constants for the sorted key set.
`timescale 1ns / 1ps

package sks_pkg;

    localparam int KEY_W            = 32;
    localparam int CMD_W            = 3;
    localparam int COUNT_W          = 5;
    localparam int DEFAULT_CAPACITY = 16;

    // Command codes carried in the request.
    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LIST_ASC  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST_DESC = 3'd4;

    // One request transfer.
    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [KEY_W-1:0] key;
    } req_t;

    // One response transfer.
    typedef struct packed {
        logic                    ok;
        logic                    has_value;
        logic signed [KEY_W-1:0] value;
        logic                    last;
        logic [COUNT_W-1:0]      count;
    } rsp_t;

    // Operation that every cell of the chain performs in a cycle.
    typedef enum logic [2:0] {
        OP_HOLD   = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_ROT_L  = 3'd3,
        OP_ROT_R  = 3'd4
    } cell_op_t;

    // Control broadcast from the sequencer to all cells.
    typedef struct packed {
        cell_op_t                op;
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] head;
        logic signed [KEY_W-1:0] tail;
    } cell_ctl_t;

endpackage

FILE: sv/sorted_key_set.sv
// Top level of the sorted key set: command sequencer and cell chain.
`timescale 1ns / 1ps

// Keeps up to CAPACITY distinct signed keys in ascending order in a chain of
// cells, one key per cell. Every cell compares its key with the request key
// at once, so insert, delete, search and unused commands each give one
// response, and a new request can be taken in the cycle after unless the
// response stalls. A listing rotates the chain by one cell per cycle while
// the response is not stalled and gives one response per stored key; the
// request is taken without a response, then one key goes out per rotation.
// Listing an empty set gives a single response. The chain is back in order
// when a listing ends. The response register lets a request be taken in the
// cycle in which the previous response transfers; a stalled response holds
// the sequencer. The count field carries the low five bits of the occupancy.
module sorted_key_set #(
    parameter int CAPACITY = sks_pkg::DEFAULT_CAPACITY
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  sks_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sks_pkg::rsp_t rsp
);
    import sks_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] remain_reg, remain_next;
    logic          desc_reg, desc_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    cell_ctl_t               ctl;
    logic signed [KEY_W-1:0] keys [CAPACITY];
    logic [CAPACITY-1:0]     lt_vec;
    logic [CAPACITY-1:0]     eq_vec;
    logic [KEY_W-1:0]        tail_parts [CAPACITY];
    logic [KEY_W-1:0]        tail_or;
    logic                    hit;
    logic                    full;
    logic                    rsp_free;
    logic                    accept;

    // Handshake.
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == ST_IDLE) && rsp_free);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Membership and fullness from the cell comparisons.
    assign hit  = |eq_vec;
    assign full = cnt_reg == CW'(CAPACITY);

    // The last occupied cell is selected by an AND-OR over the chain.
    always_comb
    begin
        tail_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail_or = tail_or | tail_parts[i];
        end
    end

    // The cell chain.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [KEY_W-1:0] left_key;
        logic                    left_lt;
        logic signed [KEY_W-1:0] right_key;

        if (i == 0)
        begin : g_first
            assign left_key = ctl.tail;
            assign left_lt  = 1'b1;
        end
        else
        begin : g_inner
            assign left_key = keys[i-1];
            assign left_lt  = lt_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_key = keys[i];
        end
        else
        begin : g_mid
            assign right_key = keys[i+1];
        end

        sks_cell #(
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .count     (cnt_reg),
            .left_key  (left_key),
            .left_lt   (left_lt),
            .right_key (right_key),
            .key       (keys[i]),
            .lt        (lt_vec[i]),
            .eq        (eq_vec[i]),
            .tail_part (tail_parts[i])
        );
    end

    // Sequencer: decodes commands, drives the chain and loads the response.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        remain_next    = remain_reg;
        desc_next      = desc_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ctl.op         = OP_HOLD;
        ctl.key        = req.key;
        ctl.head       = keys[0];
        ctl.tail       = $signed(tail_or);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.ok        = 1'b0;
                    rsp_next.has_value = 1'b0;
                    rsp_next.value     = '0;
                    rsp_next.last      = 1'b1;
                    rsp_valid_next     = 1'b1;
                    unique case (req.cmd)
                        CMD_INSERT:
                        begin
                            if (!hit && !full)
                            begin
                                ctl.op      = OP_INSERT;
                                cnt_next    = cnt_reg + CW'(1);
                                rsp_next.ok = 1'b1;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (hit)
                            begin
                                ctl.op      = OP_DELETE;
                                cnt_next    = cnt_reg - CW'(1);
                                rsp_next.ok = 1'b1;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            rsp_next.ok = hit;
                        end
                        CMD_LIST_ASC, CMD_LIST_DESC:
                        begin
                            if (cnt_reg != '0)
                            begin
                                // Responses come from the listing state.
                                rsp_valid_next = rsp_valid_reg && rsp_stall;
                                state_next     = ST_LIST;
                                remain_next    = cnt_reg;
                                desc_next      = (req.cmd == CMD_LIST_DESC);
                            end
                        end
                        default:
                        begin
                            rsp_next.ok = 1'b0;
                        end
                    endcase
                    rsp_next.count = COUNT_W'(cnt_next);
                end
            end
            ST_LIST:
            begin
                if (rsp_free)
                begin
                    rsp_next.ok        = 1'b0;
                    rsp_next.has_value = 1'b1;
                    rsp_next.value     = desc_reg ? ctl.tail : ctl.head;
                    rsp_next.last      = (remain_reg == CW'(1));
                    rsp_next.count     = COUNT_W'(cnt_reg);
                    rsp_valid_next     = 1'b1;
                    ctl.op             = desc_reg ? OP_ROT_R : OP_ROT_L;
                    remain_next        = remain_reg - CW'(1);
                    if (remain_reg == CW'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            remain_reg    <= '0;
            desc_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            remain_reg    <= remain_next;
            desc_reg      <= desc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

FILE: sv/sks_cell.sv
// One storage cell of the sorted key chain.
`timescale 1ns / 1ps

module sks_cell #(
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  logic                             clk,
    input  sks_pkg::cell_ctl_t               ctl,
    input  logic [CW-1:0]                    count,
    input  logic signed [sks_pkg::KEY_W-1:0] left_key,
    input  logic                             left_lt,
    input  logic signed [sks_pkg::KEY_W-1:0] right_key,
    output logic signed [sks_pkg::KEY_W-1:0] key,
    output logic                             lt,
    output logic                             eq,
    output logic [sks_pkg::KEY_W-1:0]        tail_part
);
    import sks_pkg::*;

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic                    valid;
    logic                    is_tail;

    // Position of this cell relative to the current occupancy.
    assign valid   = count > CW'(IDX);
    assign is_tail = count == CW'(IDX + 1);

    // Compare against the broadcast key; only occupied cells take part.
    assign key       = key_reg;
    assign lt        = valid && (key_reg < ctl.key);
    assign eq        = valid && (key_reg == ctl.key);
    assign tail_part = is_tail ? key_reg : '0;

    // Next value: keep, take the new key, a neighbor's key or, at the tail on a left rotation, the head key.
    always_comb
    begin
        key_next = key_reg;
        unique case (ctl.op)
            OP_HOLD:
            begin
                key_next = key_reg;
            end
            OP_INSERT:
            begin
                if (lt)
                    key_next = key_reg;
                else if (left_lt)
                    key_next = ctl.key;
                else
                    key_next = left_key;
            end
            OP_DELETE:
            begin
                if (!lt)
                    key_next = right_key;
            end
            OP_ROT_L:
            begin
                if (is_tail)
                    key_next = ctl.head;
                else if (valid)
                    key_next = right_key;
            end
            OP_ROT_R:
            begin
                if (valid)
                    key_next = left_key;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule
